[design/isba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isba_pkg
// shared constants for the interval bound adder
// ----------------------------------------------------------------------------
package isba_pkg;

	localparam logic [63:0] POS_INF = 64'h7ff0000000000000;
	localparam logic [63:0] NEG_INF = 64'hfff0000000000000;
	localparam logic [63:0] MAX_FIN = 64'h7fefffffffffffff;
	localparam logic [63:0] SIGN_BIT = 64'h8000000000000000;
	localparam logic [63:0] QUIET_BIT = 64'h0008000000000000;

	typedef logic [63:0] word_t;

endpackage

[design/interval_sum_bound_adder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_sum_bound_adder_core
// binary64 add with directed rounding for interval lower and upper bounds
// ----------------------------------------------------------------------------
// channel   direction  signals
// command   in         start, req_type, lhs_bits, rhs_bits (busy is out)
// result    out        done, sum_bits
//
// five register stages: align, add, normalize (two halves), round
// one transaction accepted per cycle; done is start delayed through v_s1 to v_s5
// busy is held low: the receiver cannot stall, so nothing ever backs up
// arst_n clears the valid bits only
module interval_sum_bound_adder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                req_type,
	input  isba_pkg::word_t     lhs_bits,
	input  isba_pkg::word_t     rhs_bits,
	output logic                done,
	output isba_pkg::word_t     sum_bits
);
	import isba_pkg::*;

	// stage 1: special cases, swap and align
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        up_s1, up_s2, up_s3, up_s4;
	logic        sp_s1, sp_s2, sp_s3, sp_s4;
	word_t       spv_s1, spv_s2, spv_s3, spv_s4;
	logic        sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic        sub_s1;
	logic [63:0] ma_s1, mb_s1;
	logic [11:0] e_s1, e_s2, e_s3, e_s4;
	logic [63:0] s_s2, s_s3, s_s4;
	word_t       res_s5;

	logic        c_lz, c_rz, c_ln, c_rn, c_lpi, c_rpi, c_lni, c_rni;
	logic        c_sp;
	word_t       c_spv;
	logic        c_swap;
	logic [10:0] c_ea, c_eb, c_xa, c_xb;
	logic [63:0] c_ma, c_mb, c_xma, c_xmb, c_sh;
	logic [11:0] c_d;
	logic        c_stk;

	assign busy = 1'b0;

	always_comb begin
		c_lz = (lhs_bits[62:0] == 63'd0);
		c_rz = (rhs_bits[62:0] == 63'd0);
		c_ln = (lhs_bits[62:52] == 11'h7ff) && (lhs_bits[51:0] != 52'd0);
		c_rn = (rhs_bits[62:52] == 11'h7ff) && (rhs_bits[51:0] != 52'd0);
		c_lpi = (lhs_bits == POS_INF);
		c_rpi = (rhs_bits == POS_INF);
		c_lni = (lhs_bits == NEG_INF);
		c_rni = (rhs_bits == NEG_INF);
		c_sp = 1'b1;
		if (!req_type && (c_lpi || c_rpi))
			c_spv = POS_INF;
		else if (c_lni || c_rni)
			c_spv = NEG_INF;
		else if (c_lpi || c_rpi)
			c_spv = POS_INF;
		else if (c_lz && c_rz) begin
			if (!req_type)
				c_spv = (!lhs_bits[63] && !rhs_bits[63]) ? 64'd0 : SIGN_BIT;
			else
				c_spv = (lhs_bits[63] && rhs_bits[63]) ? SIGN_BIT : 64'd0;
		end else if (c_lz)
			c_spv = rhs_bits;
		else if (c_rz)
			c_spv = lhs_bits;
		else if (c_ln)
			c_spv = lhs_bits | QUIET_BIT;
		else if (c_rn)
			c_spv = rhs_bits | QUIET_BIT;
		else begin
			c_spv = 64'd0;
			c_sp = 1'b0;
		end
		c_ea = (lhs_bits[62:52] == 11'd0) ? 11'd1 : lhs_bits[62:52];
		c_eb = (rhs_bits[62:52] == 11'd0) ? 11'd1 : rhs_bits[62:52];
		c_ma = {1'b0, 1'b0, (lhs_bits[62:52] != 11'd0), lhs_bits[51:0], 9'd0} << 1;
		c_mb = {1'b0, 1'b0, (rhs_bits[62:52] != 11'd0), rhs_bits[51:0], 9'd0} << 1;
		c_swap = (c_eb > c_ea) || ((c_eb == c_ea) && (c_mb > c_ma));
		c_xa = c_swap ? c_eb : c_ea;
		c_xb = c_swap ? c_ea : c_eb;
		c_xma = c_swap ? c_mb : c_ma;
		c_xmb = c_swap ? c_ma : c_mb;
		c_d = {1'b0, c_xa} - {1'b0, c_xb};
		if (c_d >= 12'd64) begin
			c_stk = 1'b0;
			c_sh = {63'd0, (c_xmb != 64'd0)};
		end else begin
			c_sh = c_xmb >> c_d[5:0];
			c_stk = ((c_xmb & ~(64'hffffffffffffffff << c_d[5:0])) != 64'd0);
			c_sh[0] = c_sh[0] | c_stk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		up_s1 <= req_type;
		sp_s1 <= c_sp;
		spv_s1 <= c_spv;
		sgn_s1 <= c_swap ? rhs_bits[63] : lhs_bits[63];
		sub_s1 <= lhs_bits[63] ^ rhs_bits[63];
		ma_s1 <= c_xma;
		mb_s1 <= c_sh;
		e_s1 <= {1'b0, c_xa};
	end

	// stage 2: add or subtract
	logic [63:0] c_s;
	logic [11:0] c_e2;
	logic        c_z2;
	always_comb begin
		c_e2 = e_s1;
		c_z2 = 1'b0;
		if (!sub_s1) begin
			c_s = ma_s1 + mb_s1;
			if (c_s[63]) begin
				c_s = {1'b0, c_s[63:2], c_s[1] | c_s[0]};
				c_e2 = e_s1 + 12'd1;
			end
		end else begin
			c_s = ma_s1 - mb_s1;
			c_z2 = (c_s == 64'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		up_s2 <= up_s1;
		sp_s2 <= sp_s1 | c_z2;
		spv_s2 <= sp_s1 ? spv_s1 : (up_s1 ? 64'd0 : SIGN_BIT);
		sgn_s2 <= sgn_s1;
		s_s2 <= c_s;
		e_s2 <= c_e2;
	end

	// stages 3 and 4: normalize, coarse then fine (shift limited by exponent)
	logic [5:0]  c_lz3, c_lz4;
	logic [11:0] c_lim3, c_lim4, c_k3, c_k4;
	always_comb begin
		c_lz3 = 6'd0;
		for (int i = 0; i <= 62; i++) begin
			if (s_s2[i])
				c_lz3 = 6'(62 - i);
		end
		if (s_s2[62:0] == 63'd0) c_lz3 = 6'd62;
		c_lim3 = e_s2 - 12'd1;
		c_k3 = ({6'd0, c_lz3} < c_lim3) ? {6'd0, c_lz3} : c_lim3;
		c_k3 = {c_k3[11:3], 3'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		up_s3 <= up_s2;
		sp_s3 <= sp_s2;
		spv_s3 <= spv_s2;
		sgn_s3 <= sgn_s2;
		s_s3 <= s_s2 << c_k3[5:0];
		e_s3 <= e_s2 - c_k3;
	end

	always_comb begin
		c_lz4 = 6'd0;
		for (int i = 0; i < 8; i++) begin
			if (!s_s3[62 - i] && c_lz4 == 6'(i)) c_lz4 = 6'(i + 1);
		end
		c_lim4 = e_s3 - 12'd1;
		c_k4 = ({6'd0, c_lz4} < c_lim4) ? {6'd0, c_lz4} : c_lim4;
	end

	always_ff @(posedge clk) begin
		up_s4 <= up_s3;
		sp_s4 <= sp_s3;
		spv_s4 <= spv_s3;
		sgn_s4 <= sgn_s3;
		s_s4 <= s_s3 << c_k4[3:0];
		e_s4 <= e_s3 - c_k4;
	end

	// stage 5: round and pack
	logic [53:0] c_mant;
	logic [11:0] c_e5;
	logic        c_away;
	word_t       c_res;
	always_comb begin
		c_mant = {1'b0, s_s4[62:10]};
		c_e5 = e_s4;
		c_away = sgn_s4 ? !up_s4 : up_s4;
		if ((s_s4[9:0] != 10'd0) && c_away) begin
			c_mant = c_mant + 54'd1;
			if (c_mant[53]) begin
				c_mant = c_mant >> 1;
				c_e5 = c_e5 + 12'd1;
			end
		end
		if (sp_s4)
			c_res = spv_s4;
		else if (c_e5 >= 12'h7ff)
			c_res = {sgn_s4, 63'd0} | (c_away ? POS_INF : MAX_FIN);
		else if (c_mant[52])
			c_res = {sgn_s4, c_e5[10:0], c_mant[51:0]};
		else
			c_res = {sgn_s4, 11'd0, c_mant[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5 <= c_res;
	end

	assign done = v_s5;
	assign sum_bits = res_s5;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done) else $error("result strobe missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s4)) else $error("spurious result");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !sp_s4 && e_s4 > 12'd1) |-> s_s4[62]) else $error("not normalized");
`endif

endmodule
